// File: src/qrs_pkg.sv
// Shared constants and types for the quadratic root solver.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package qrs_pkg;

    localparam int COEFF_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;

    // Roots are always delivered in a 32-bit word
    localparam int ROOT_W = 32;
    localparam logic [ROOT_W-1:0] ROOT_POS_LIM = {1'b0, {(ROOT_W-1){1'b1}}};
    localparam logic [ROOT_W-1:0] ROOT_NEG_LIM = {1'b1, {(ROOT_W-1){1'b0}}};

    typedef enum logic [1:0] {
        RC_NONE = 2'd0,
        RC_ONE  = 2'd1,
        RC_TWO  = 2'd2
    } t_root_count;

    typedef struct packed {
        t_root_count              root_count;
        logic signed [ROOT_W-1:0] root_plus;
        logic signed [ROOT_W-1:0] root_minus;
        logic                     invalid;
        logic                     saturated;
    } t_result;

endpackage

// File: src/qrs_if.sv
// Valid/ready channel interfaces for the coefficient input and the root result.
// Depends on qrs_pkg.
`timescale 1ns / 1ps

interface qrs_in_if #(
    parameter int COEFF_BITS = qrs_pkg::COEFF_BITS_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic signed [COEFF_BITS-1:0] a_numer;
    logic        [COEFF_BITS-2:0] a_denom;
    logic signed [COEFF_BITS-1:0] b_numer;
    logic        [COEFF_BITS-2:0] b_denom;
    logic signed [COEFF_BITS-1:0] c_numer;
    logic        [COEFF_BITS-2:0] c_denom;

    modport source (output valid, a_numer, a_denom, b_numer, b_denom, c_numer, c_denom,
                    input ready);
    modport sink   (input valid, a_numer, a_denom, b_numer, b_denom, c_numer, c_denom,
                    output ready);
endinterface

interface qrs_out_if ();
    logic                                     valid;
    logic                                     ready;
    qrs_pkg::t_root_count                     root_count;
    logic signed [qrs_pkg::ROOT_W-1:0]        root_plus;
    logic signed [qrs_pkg::ROOT_W-1:0]        root_minus;
    logic                                     invalid;
    logic                                     saturated;

    modport source (output valid, root_count, root_plus, root_minus, invalid, saturated,
                    input ready);
    modport sink   (input valid, root_count, root_plus, root_minus, invalid, saturated,
                    output ready);
endinterface

// File: src/quadratic_root_solver_unit.sv
// Quadratic root solver top level: fully pipelined exact real-root datapath.
// Depends on qrs_pkg and the channel interfaces in qrs_if.sv.
`timescale 1ns / 1ps

// Usage
//   i_in  : one coefficient set per transfer (a, b, c as signed numerator over
//           positive denominator). Accepted when valid and ready are both high.
//   o_out : one result per input transfer, in order: root count, the two roots
//           in Q(32-FRAC_BITS).FRAC_BITS truncated toward zero, invalid and
//           saturated flags.
//   Throughput: one coefficient set per clock while the skid register is empty.
//   Depth: set by the bit-serial square root, one result bit per stage,
//           followed by a 32-stage restoring divider pair.
//   Reset (i_rst_n low, synchronous): all valid bits clear, pipeline empties,
//           o_out.valid drops. Data registers are not reset.
//   Stall: the output register is backed by a one-entry skid register. While
//           the receiver holds ready low the pipeline keeps moving until the
//           skid fills; only then does i_in.ready fall and the whole pipeline
//           freeze in place, losing and repeating nothing.
//   Zero leading numerator (or zero denominator) flags invalid with all other
//   fields zero; a negative discriminant gives root count zero, roots zero.
module quadratic_root_solver_unit #(
    parameter int COEFF_BITS = qrs_pkg::COEFF_BITS_DEF,
    parameter int FRAC_BITS  = qrs_pkg::FRAC_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    qrs_in_if.sink     i_in,
    qrs_out_if.source  o_out
);

    // ---------------------------------------------------------------------
    // Widths, all derived from the coefficient and fraction widths
    // ---------------------------------------------------------------------
    localparam int RW_OUT = qrs_pkg::ROOT_W;
    localparam int MAGW   = COEFF_BITS;          // |numerator| up to 2^(C-1)
    localparam int DENW   = COEFF_BITS - 1;
    localparam int BN2W   = 2 * MAGW;
    localparam int ADCDW  = 2 * DENW;
    localparam int BD2W   = 2 * DENW;
    localparam int ANBDW  = MAGW + DENW;
    localparam int S1W    = BN2W + ADCDW;        // b^2 * ad * cd
    localparam int S2W    = BN2W + BD2W;         // a * c * bd^2
    localparam int DW     = S2W + 4;             // signed scaled discriminant
    localparam int DMW    = DW - 1;
    localparam int DLW    = (DMW + 1) / 2;
    localparam int DHW    = DMW - DLW;
    localparam int MPW    = DMW + ADCDW;
    localparam int MSW    = MPW + 2 * FRAC_BITS;
    localparam int SW     = (MSW + 1) / 2;       // square root bits = stages
    localparam int MW     = 2 * SW;
    localparam int RSW    = SW + 2;
    localparam int PMW    = MAGW + ADCDW;
    localparam int PW     = PMW + FRAC_BITS;
    localparam int QW     = ANBDW + DENW + 1;
    localparam int LW     = ((PW > SW + 1) ? PW : SW + 1) + 2;
    localparam int NW     = LW - 1;
    localparam int DVW    = (NW > RW_OUT) ? NW : RW_OUT + 1;
    localparam int RMW    = QW + 1;
    localparam int CMPW   = (DVW > QW) ? DVW : QW;

    // Stage map
    localparam int ST_SQ0 = 5;
    localparam int ST_CA  = ST_SQ0 + SW;
    localparam int ST_CB  = ST_CA + 1;
    localparam int ST_DV0 = ST_CB + 1;
    localparam int ST_FMT = ST_DV0 + RW_OUT;
    localparam int NST    = ST_FMT + 1;

    // ---------------------------------------------------------------------
    // Stage payload types
    // ---------------------------------------------------------------------
    typedef struct packed {
        logic inv;
        logic dneg;
        logic dzero;
    } t_flags;

    typedef struct packed {
        logic [BN2W-1:0]  bn2;
        logic [ADCDW-1:0] adcd;
        logic [BN2W-1:0]  ancn;
        logic [BD2W-1:0]  bd2;
        logic [ANBDW-1:0] anbd;
        logic [MAGW-1:0]  bn;
        logic [DENW-1:0]  cd;
        logic             an_neg;
        logic             pneg;
        logic             tsub;
        logic             inv;
    } t_s0;

    typedef struct packed {
        logic [S1W-1:0]   s1;
        logic [S2W-1:0]   s2;
        logic [PMW-1:0]   pm;
        logic [QW-1:0]    q;
        logic [ADCDW-1:0] adcd;
        logic             an_neg;
        logic             pneg;
        logic             tsub;
        logic             inv;
    } t_s1;

    typedef struct packed {
        logic [DW-1:0]    disc;
        logic [PW-1:0]    p;
        logic [QW-1:0]    q;
        logic [ADCDW-1:0] adcd;
        logic             an_neg;
        logic             pneg;
        logic             inv;
    } t_s2;

    typedef struct packed {
        logic [PW-1:0] p;
        logic          pneg;
        logic [QW-1:0] q;
        logic          an_neg;
        t_flags        fl;
    } t_side;

    typedef struct packed {
        logic [DLW+ADCDW-1:0] plo;
        logic [DHW+ADCDW-1:0] phi;
        t_side                side;
    } t_s3;

    typedef struct packed {
        logic [SW-1:0]  root;
        logic [RSW-1:0] rem;
        logic [MW-1:0]  m;
        t_side          side;
    } t_sq;

    typedef struct packed {
        logic signed [LW-1:0] lo_p;
        logic signed [LW-1:0] hi_p;
        logic signed [LW-1:0] lo_m;
        logic signed [LW-1:0] hi_m;
        logic [QW-1:0]        q;
        t_flags               fl;
    } t_ca;

    typedef struct packed {
        logic [RW_OUT-1:0] dl;
        logic [RMW-1:0]    rem;
        logic [RW_OUT-1:0] quo;
        logic              neg;
        logic              sat;
    } t_lane;

    typedef struct packed {
        t_lane         lp;
        t_lane         lm;
        logic [QW-1:0] q;
        t_flags        fl;
    } t_dv;

    // ---------------------------------------------------------------------
    // Lane helpers
    // ---------------------------------------------------------------------
    function automatic t_lane lane_init(input logic signed [LW-1:0] lo,
                                        input logic signed [LW-1:0] hi,
                                        input logic [QW-1:0] q);
        t_lane                l;
        logic signed [LW-1:0] mag;
        logic [DVW-1:0]       dvd;
        logic [DVW-1:0]       top;
        l.neg = lo[LW-1];
        // negative side rounds toward zero through the upper bound
        mag   = l.neg ? -hi : lo;
        dvd   = DVW'(mag[NW-1:0]);
        top   = dvd >> RW_OUT;
        l.sat = CMPW'(top) >= CMPW'(q);
        l.dl  = dvd[RW_OUT-1:0];
        l.rem = RMW'(top);
        l.quo = '0;
        return l;
    endfunction

    function automatic t_lane lane_step(input t_lane s, input logic [QW-1:0] q);
        t_lane          l;
        logic [RMW-1:0] rs;
        logic           ge;
        l     = s;
        rs    = {s.rem[RMW-2:0], s.dl[RW_OUT-1]};
        ge    = rs >= RMW'(q);
        l.rem = ge ? rs - RMW'(q) : rs;
        l.quo = {s.quo[RW_OUT-2:0], ge};
        l.dl  = {s.dl[RW_OUT-2:0], 1'b0};
        return l;
    endfunction

    // {over, clipped signed value}
    function automatic logic [RW_OUT:0] lane_clip(input t_lane l);
        logic              over;
        logic [RW_OUT-1:0] val;
        over = l.sat || (l.neg ? (l.quo > qrs_pkg::ROOT_NEG_LIM)
                               : (l.quo > qrs_pkg::ROOT_POS_LIM));
        val  = over ? (l.neg ? qrs_pkg::ROOT_NEG_LIM : qrs_pkg::ROOT_POS_LIM) : l.quo;
        return {over, l.neg ? -val : val};
    endfunction

    // ---------------------------------------------------------------------
    // Flow control: global advance, stalls only when the skid is occupied
    // ---------------------------------------------------------------------
    logic [NST-1:0]   r_vld;
    logic             r_out_vld, r_skid_vld;
    qrs_pkg::t_result r_out, r_skid;
    logic             en, push;

    assign en         = !r_skid_vld;
    assign push       = en && r_vld[NST-1];
    assign i_in.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NST-2:0], i_in.valid};
        end
    end

    // ---------------------------------------------------------------------
    // Stage 0: magnitudes, first products
    // ---------------------------------------------------------------------
    t_s0 r_s0, n_s0;

    always_comb begin
        logic [MAGW-1:0] an, bn, cn;
        logic [DENW-1:0] ad, bd, cd;
        logic            an_neg, bn_neg, cn_neg;
        an_neg = i_in.a_numer[COEFF_BITS-1];
        bn_neg = i_in.b_numer[COEFF_BITS-1];
        cn_neg = i_in.c_numer[COEFF_BITS-1];
        an = an_neg ? MAGW'(~$unsigned(i_in.a_numer) + 1'b1) : $unsigned(i_in.a_numer);
        bn = bn_neg ? MAGW'(~$unsigned(i_in.b_numer) + 1'b1) : $unsigned(i_in.b_numer);
        cn = cn_neg ? MAGW'(~$unsigned(i_in.c_numer) + 1'b1) : $unsigned(i_in.c_numer);
        ad = i_in.a_denom;
        bd = i_in.b_denom;
        cd = i_in.c_denom;
        n_s0.bn2    = BN2W'(bn) * BN2W'(bn);
        n_s0.adcd   = ADCDW'(ad) * ADCDW'(cd);
        n_s0.ancn   = BN2W'(an) * BN2W'(cn);
        n_s0.bd2    = BD2W'(bd) * BD2W'(bd);
        n_s0.anbd   = ANBDW'(an) * ANBDW'(bd);
        n_s0.bn     = bn;
        n_s0.cd     = cd;
        n_s0.an_neg = an_neg;
        n_s0.pneg   = !bn_neg ^ an_neg;
        n_s0.tsub   = (an_neg == cn_neg);
        n_s0.inv    = (an == '0) || (ad == '0) || (bd == '0) || (cd == '0);
    end

    // ---------------------------------------------------------------------
    // Stage 1: b^2*ad*cd, a*c*bd^2, b*ad*cd, 2*a*bd*cd
    // ---------------------------------------------------------------------
    t_s1 r_s1, n_s1;

    always_comb begin
        logic [ANBDW+DENW-1:0] qp;
        qp          = (ANBDW + DENW)'(r_s0.anbd) * (ANBDW + DENW)'(r_s0.cd);
        n_s1.s1     = S1W'(r_s0.bn2) * S1W'(r_s0.adcd);
        n_s1.s2     = S2W'(r_s0.ancn) * S2W'(r_s0.bd2);
        n_s1.pm     = PMW'(r_s0.bn) * PMW'(r_s0.adcd);
        n_s1.q      = {qp, 1'b0};
        n_s1.adcd   = r_s0.adcd;
        n_s1.an_neg = r_s0.an_neg;
        n_s1.pneg   = r_s0.pneg;
        n_s1.tsub   = r_s0.tsub;
        n_s1.inv    = r_s0.inv;
    end

    // ---------------------------------------------------------------------
    // Stage 2: scaled discriminant, numerator offset
    // ---------------------------------------------------------------------
    t_s2 r_s2, n_s2;

    always_comb begin
        logic [DW-1:0] u1, u2;
        u1          = DW'(r_s1.s1);
        u2          = DW'({r_s1.s2, 2'b00});
        n_s2.disc   = r_s1.tsub ? u1 - u2 : u1 + u2;
        n_s2.p      = {r_s1.pm, {FRAC_BITS{1'b0}}};
        n_s2.q      = r_s1.q;
        n_s2.adcd   = r_s1.adcd;
        n_s2.an_neg = r_s1.an_neg;
        n_s2.pneg   = r_s1.pneg;
        n_s2.inv    = r_s1.inv;
    end

    // ---------------------------------------------------------------------
    // Stage 3: classify, split product disc*ad*cd into two halves
    // ---------------------------------------------------------------------
    t_s3 r_s3, n_s3;

    always_comb begin
        logic [DMW-1:0] dm;
        dm                  = r_s2.disc[DMW-1:0];
        n_s3.plo            = (DLW + ADCDW)'(dm[DLW-1:0]) * (DLW + ADCDW)'(r_s2.adcd);
        n_s3.phi            = (DHW + ADCDW)'(dm[DMW-1:DLW]) * (DHW + ADCDW)'(r_s2.adcd);
        n_s3.side.p         = r_s2.p;
        n_s3.side.pneg      = r_s2.pneg;
        n_s3.side.q         = r_s2.q;
        n_s3.side.an_neg    = r_s2.an_neg;
        n_s3.side.fl.inv    = r_s2.inv;
        n_s3.side.fl.dneg   = r_s2.disc[DW-1];
        n_s3.side.fl.dzero  = (r_s2.disc == '0);
    end

    // ---------------------------------------------------------------------
    // Stage 4: join halves, scale by 2^(2F), seed the square root
    // ---------------------------------------------------------------------
    t_sq r_s4, n_s4;

    always_comb begin
        logic [MPW-1:0] mprod;
        mprod      = MPW'(r_s3.plo) + (MPW'(r_s3.phi) << DLW);
        n_s4.root  = '0;
        n_s4.rem   = '0;
        n_s4.m     = MW'({mprod, {(2 * FRAC_BITS){1'b0}}});
        n_s4.side  = r_s3.side;
    end

    // ---------------------------------------------------------------------
    // Square root: one restoring step (one root bit) per stage
    // ---------------------------------------------------------------------
    t_sq r_sq [SW];
    t_sq n_sq [SW];

    always_comb begin
        t_sq            src;
        logic [RSW-1:0] rs, trial;
        logic           ge;
        for (int j = 0; j < SW; j++) begin
            src          = (j == 0) ? r_s4 : r_sq[(j == 0) ? 0 : j - 1];
            rs           = {src.rem[RSW-3:0], src.m[MW-1 -: 2]};
            trial        = {src.root, 2'b01};
            ge           = rs >= trial;
            n_sq[j].rem  = ge ? rs - trial : rs;
            n_sq[j].root = {src.root[SW-2:0], ge};
            n_sq[j].m    = {src.m[MW-3:0], 2'b00};
            n_sq[j].side = src.side;
        end
    end

    // ---------------------------------------------------------------------
    // Combine A: bounds p +- floor/ceil(sqrt) for both roots
    // ---------------------------------------------------------------------
    t_ca r_ca, n_ca;

    always_comb begin
        t_sq                  s;
        logic signed [LW-1:0] pv, sf, sc;
        logic                 plus_p, plus_m;
        s      = r_sq[SW-1];
        pv     = s.side.pneg ? -$signed(LW'(s.side.p)) : $signed(LW'(s.side.p));
        sf     = $signed(LW'(s.root));
        sc     = sf + $signed(LW'(s.rem != '0));
        plus_p = !s.side.an_neg;
        plus_m = s.side.an_neg;
        n_ca.lo_p = plus_p ? pv + sf : pv - sc;
        n_ca.hi_p = plus_p ? pv + sc : pv - sf;
        n_ca.lo_m = plus_m ? pv + sf : pv - sc;
        n_ca.hi_m = plus_m ? pv + sc : pv - sf;
        n_ca.q    = s.side.q;
        n_ca.fl   = s.side.fl;
    end

    // ---------------------------------------------------------------------
    // Combine B: dividend magnitude and early overflow check
    // ---------------------------------------------------------------------
    t_dv r_cb, n_cb;

    always_comb begin
        n_cb.lp = lane_init(r_ca.lo_p, r_ca.hi_p, r_ca.q);
        n_cb.lm = lane_init(r_ca.lo_m, r_ca.hi_m, r_ca.q);
        n_cb.q  = r_ca.q;
        n_cb.fl = r_ca.fl;
    end

    // ---------------------------------------------------------------------
    // Divider pair: one quotient bit per stage
    // ---------------------------------------------------------------------
    t_dv r_dv [RW_OUT];
    t_dv n_dv [RW_OUT];

    always_comb begin
        t_dv src;
        for (int k = 0; k < RW_OUT; k++) begin
            src        = (k == 0) ? r_cb : r_dv[(k == 0) ? 0 : k - 1];
            n_dv[k].lp = lane_step(src.lp, src.q);
            n_dv[k].lm = lane_step(src.lm, src.q);
            n_dv[k].q  = src.q;
            n_dv[k].fl = src.fl;
        end
    end

    // ---------------------------------------------------------------------
    // Format: clip, sign, special cases
    // ---------------------------------------------------------------------
    qrs_pkg::t_result r_fmt, n_fmt;

    always_comb begin
        t_dv             d;
        logic [RW_OUT:0] cp, cm;
        d     = r_dv[RW_OUT-1];
        cp    = lane_clip(d.lp);
        cm    = lane_clip(d.lm);
        n_fmt = '0;
        if (d.fl.inv) begin
            n_fmt.invalid = 1'b1;
        end else if (!d.fl.dneg) begin
            n_fmt.root_count = d.fl.dzero ? qrs_pkg::RC_ONE : qrs_pkg::RC_TWO;
            n_fmt.root_plus  = cp[RW_OUT-1:0];
            n_fmt.root_minus = cm[RW_OUT-1:0];
            n_fmt.saturated  = cp[RW_OUT] | cm[RW_OUT];
        end
    end

    // Pipeline data registers
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0  <= n_s0;
            r_s1  <= n_s1;
            r_s2  <= n_s2;
            r_s3  <= n_s3;
            r_s4  <= n_s4;
            r_sq  <= n_sq;
            r_ca  <= n_ca;
            r_cb  <= n_cb;
            r_dv  <= n_dv;
            r_fmt <= n_fmt;
        end
    end

    // ---------------------------------------------------------------------
    // Output register with skid
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (o_out.ready) begin
                r_skid_vld <= 1'b0;
            end
        end else if (!r_out_vld || o_out.ready) begin
            r_out_vld <= push;
        end else if (push) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (o_out.ready) begin
                r_out <= r_skid;
            end
        end else if (!r_out_vld || o_out.ready) begin
            if (push) begin
                r_out <= r_fmt;
            end
        end else if (push) begin
            r_skid <= r_fmt;
        end
    end

    assign o_out.valid      = r_out_vld;
    assign o_out.root_count = r_out.root_count;
    assign o_out.root_plus  = r_out.root_plus;
    assign o_out.root_minus = r_out.root_minus;
    assign o_out.invalid    = r_out.invalid;
    assign o_out.saturated  = r_out.saturated;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_invalid_clean : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.invalid |->
            o_out.root_count == qrs_pkg::RC_NONE && o_out.root_plus == '0 &&
            o_out.root_minus == '0 && !o_out.saturated)
        else $error("invalid result carries roots");

    a_repeated_equal : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.root_count == qrs_pkg::RC_ONE |->
            o_out.root_plus == o_out.root_minus)
        else $error("repeated root differs between outputs");

    a_none_unsat : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.root_count == qrs_pkg::RC_NONE |-> !o_out.saturated)
        else $error("saturation flagged without roots");

    a_sqrt_rem : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[ST_CA-1] |-> r_sq[SW-1].rem <= RSW'({r_sq[SW-1].root, 1'b0}))
        else $error("square root remainder out of bound");

    a_skid_behind : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid holds a result with output register empty");

endmodule
